/* src/c2e_pkg.sv */
// Shared types, constants and the month table for the calendar to epoch seconds converter.
package c2e_pkg;

    localparam logic [13:0] EPOCH_YEAR         = 14'd1970;
    localparam logic [13:0] MAX_YEAR           = 14'd9999;
    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] RECIP_100          = 13'd5243;
    localparam int          RECIP_100_SHIFT    = 19;
    localparam logic [6:0]  CENTURY            = 7'd100;
    localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
    // leap days among years 1..1969
    localparam logic [8:0]  LEAPS_BEFORE_EPOCH = 9'd477;
    localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE    = 6'd60;

    // configuration register indexes
    localparam logic [1:0] CFG_LIMIT_YEAR  = 2'd0;
    localparam logic [1:0] CFG_LIMIT_MONTH = 2'd1;
    localparam logic [1:0] CFG_LIMIT_DAY   = 2'd2;

    typedef struct packed {
        logic [13:0] limit_year;
        logic [3:0]  limit_month;
        logic [4:0]  limit_day;
    } cfg_t;

    typedef struct packed {
        logic [5:0]  second_num;
        logic [5:0]  minute_num;
        logic [4:0]  hour_num;
        logic [4:0]  day_num;
        logic [3:0]  month_num;
        logic [6:0]  year_short;
        logic [13:0] year_full;
    } item_t;

    typedef struct packed {
        logic        out_of_range;
        logic [37:0] epoch_seconds;
        logic        date_valid;
    } result_t;

    // days before the first of month m; months 13..15 count as 31 days each
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* src/c2e_core.sv */
// Five-stage datapath: date checks, closed-form day count and seconds assembly.
module c2e_core
    import c2e_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    // stage enables: a stage loads when it is empty or its successor moves
    logic en1, en2, en3, en4, en5;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    assign en5      = !s5_valid_reg || out_ready;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---- stage 1: reciprocal multiplies for y/100 and (y-1)/100
    logic [13:0] in_prev_year;
    logic [26:0] qy_prod, qn_prod;
    item_t       s1_item_reg;
    logic [7:0]  s1_qy_reg, s1_qn_reg;

    assign in_prev_year = in_item.year_full - 14'd1;
    assign qy_prod      = 27'(in_item.year_full) * 27'(RECIP_100);
    assign qn_prod      = 27'(in_prev_year) * 27'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_item_reg <= in_item;
            s1_qy_reg   <= qy_prod[RECIP_100_SHIFT +: 8];
            s1_qn_reg   <= qn_prod[RECIP_100_SHIFT +: 8];
        end
    end

    // ---- stage 2: leap year, validity, range check, leap-day count, time of day
    logic [13:0] rem_wide;
    logic [6:0]  rem100;
    logic [13:0] prev_year;
    logic        leap_next;
    logic [4:0]  month_len;
    logic        valid_next, oor_next;
    logic [11:0] leaps_next;
    logic [16:0] tod_next;

    logic [13:0] s2_year_reg;
    logic [3:0]  s2_month_reg;
    logic [4:0]  s2_day_reg;
    logic        s2_leap_reg, s2_date_ok_reg, s2_oor_reg;
    logic [11:0] s2_leaps_reg;
    logic [16:0] s2_tod_reg;

    always_comb
    begin
        rem_wide  = s1_item_reg.year_full - 14'(s1_qy_reg) * 14'(CENTURY);
        rem100    = rem_wide[6:0];
        leap_next = (s1_item_reg.year_full[1:0] == 2'd0) &&
                    !((rem100 == 7'd0) && (s1_qy_reg[1:0] != 2'd0));
        case (s1_item_reg.month_num) inside
            4'd2:                     month_len = leap_next ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  month_len = 5'd30;
            default:                  month_len = 5'd31;
        endcase
        valid_next = (s1_item_reg.year_full <= MAX_YEAR) &&
                     (s1_item_reg.year_short == rem100) &&
                     (s1_item_reg.month_num >= 4'd1) && (s1_item_reg.month_num <= 4'd12) &&
                     (s1_item_reg.day_num >= 5'd1) && (s1_item_reg.day_num <= month_len);
        oor_next   = (s1_item_reg.year_full < EPOCH_YEAR) ||
                     (s1_item_reg.year_full > MAX_YEAR) ||
                     (s1_item_reg.year_full > cfg.limit_year) ||
                     ((s1_item_reg.year_full == cfg.limit_year) &&
                      ((s1_item_reg.month_num != cfg.limit_month) ||
                       (s1_item_reg.day_num > cfg.limit_day)));
        // leap days among years 1..y-1
        prev_year  = s1_item_reg.year_full - 14'd1;
        leaps_next = 12'(prev_year[13:2]) - 12'(s1_qn_reg) + 12'(s1_qn_reg[7:2]);
        tod_next   = 17'(s1_item_reg.hour_num) * 17'(SECS_PER_HOUR) +
                     17'(s1_item_reg.minute_num) * 17'(SECS_PER_MINUTE) +
                     17'(s1_item_reg.second_num);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_year_reg    <= s1_item_reg.year_full;
            s2_month_reg   <= s1_item_reg.month_num;
            s2_day_reg     <= s1_item_reg.day_num;
            s2_leap_reg    <= leap_next;
            s2_date_ok_reg <= valid_next;
            s2_oor_reg     <= oor_next;
            s2_leaps_reg   <= leaps_next;
            s2_tod_reg     <= tod_next;
        end
    end

    // ---- stage 3: whole days counted from the epoch, day of month included
    logic [12:0] year_off;
    logic [21:0] days_next;
    logic        leap_adj;

    logic [21:0] s3_days_reg;
    logic        s3_date_ok_reg, s3_oor_reg;
    logic [16:0] s3_tod_reg;

    always_comb
    begin
        year_off  = 13'(s2_year_reg - EPOCH_YEAR);
        leap_adj  = (s2_month_reg > 4'd2) && s2_leap_reg;
        days_next = 22'(year_off) * 22'(DAYS_PER_YEAR) + 22'(s2_leaps_reg) -
                    22'(LEAPS_BEFORE_EPOCH) + 22'(days_before_month(s2_month_reg)) +
                    22'(leap_adj) + 22'(s2_day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_days_reg    <= days_next;
            s3_date_ok_reg <= s2_date_ok_reg;
            s3_oor_reg     <= s2_oor_reg;
            s3_tod_reg     <= s2_tod_reg;
        end
    end

    // ---- stage 4: (days - 1) * 86400
    logic [21:0] days_m1;
    logic [38:0] day_secs_next;

    logic [38:0] s4_day_secs_reg;
    logic        s4_zero_days_reg, s4_date_ok_reg, s4_oor_reg;
    logic [16:0] s4_tod_reg;

    assign days_m1       = s3_days_reg - 22'd1;
    assign day_secs_next = 39'(days_m1) * 39'(SECS_PER_DAY);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_day_secs_reg  <= day_secs_next;
            s4_zero_days_reg <= (s3_days_reg == 22'd0);
            s4_date_ok_reg   <= s3_date_ok_reg;
            s4_oor_reg       <= s3_oor_reg;
            s4_tod_reg       <= s3_tod_reg;
        end
    end

    // ---- stage 5: add time of day; clamp the day-zero underflow; zero when rejected
    logic [38:0] sum_secs;
    logic [37:0] secs_next;
    result_t     s5_result_reg;

    always_comb
    begin
        sum_secs = s4_day_secs_reg + 39'(s4_tod_reg);
        if (s4_oor_reg)
            secs_next = 38'd0;
        else if (s4_zero_days_reg)
            secs_next = (s4_tod_reg >= SECS_PER_DAY) ?
                        38'(s4_tod_reg - SECS_PER_DAY) : 38'd0;
        else
            secs_next = sum_secs[37:0];
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_result_reg.date_valid    <= s4_date_ok_reg;
            s5_result_reg.epoch_seconds <= secs_next;
            s5_result_reg.out_of_range  <= s4_oor_reg;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_result = s5_result_reg;

    // a waiting result is never dropped
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result))
        else $error("result dropped or changed while stalled");

    // a rejected conversion always reports zero seconds
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.out_of_range |-> out_result.epoch_seconds == 38'd0)
        else $error("nonzero seconds on rejected conversion");

    // with every stage full and the output stalled, no transaction is taken
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg &&
        s5_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

/* src/calendar_to_epoch_seconds.sv */
// Top level: stream ports, configuration registers and the conversion pipeline.
//
// Converts one broken-down Gregorian date and time per transaction into seconds
// since 1970-01-01 00:00:00, with a calendar validity flag and a range flag.
//
// Channels:
//   s_axis_*  input transaction, one date/time per accepted beat
//   m_axis_*  result transaction, seconds in tdata, flags in tuser
//   cfg_*     register writes: 0 limit_year, 1 limit_month, 2 limit_day;
//             index 3 is ignored. cfg_ready is always high. Write only while
//             no transaction is in flight.
// Path: an accepted transaction moves through the stage registers in order,
//   and m_axis_tvalid rises once the last stage holds it.
// Throughput: one transaction per cycle while the output is not stalled;
//   the five stages (two reciprocal multiplies, checks, day count,
//   day-to-seconds multiply, final add) each advance independently.
// Reset: all stages empty, limits return to 2038 / 1 / 19.
// Stall: a held result stays stable in the output register; stages upstream
//   keep filling, and s_axis_tready drops only when all five are occupied.
module calendar_to_epoch_seconds
    import c2e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] year_full, [20:14] year_short, [24:21] month_num, [29:25] day_num,
    // [34:30] hour_num, [40:35] minute_num, [46:41] second_num, [47] zero
    input  logic [47:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [37:0] epoch_seconds, [39:38] zero
    output logic [39:0] m_axis_tdata,
    // [0] date_valid, [1] out_of_range
    output logic [1:0]  m_axis_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   in_item;
    result_t result;

    assign cfg_ready = 1'b1;

    // limit registers; writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_year  <= 14'd2038;
            cfg_reg.limit_month <= 4'd1;
            cfg_reg.limit_day   <= 5'd19;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LIMIT_YEAR:  cfg_reg.limit_year  <= cfg_data;
                CFG_LIMIT_MONTH: cfg_reg.limit_month <= cfg_data[3:0];
                CFG_LIMIT_DAY:   cfg_reg.limit_day   <= cfg_data[4:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // field order in the struct matches the tdata layout, highest field first
    assign in_item = item_t'(s_axis_tdata[46:0]);

    c2e_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {2'b00, result.epoch_seconds};
    assign m_axis_tuser = {result.out_of_range, result.date_valid};

endmodule
